### rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and sizing constants of the fixed-block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Largest pool that storage is sized for.
  localparam int MAX_BLOCKS = 1024;

  // Block indexes are 10 bits wide, so the link store never needs more than 1024 entries.
  localparam int IDX_W       = 10;
  localparam int IDX_SPAN    = 1 << IDX_W;
  localparam int LINK_DEPTH  = (MAX_BLOCKS < IDX_SPAN) ? MAX_BLOCKS : IDX_SPAN;
  localparam int LINK_AW     = $clog2(LINK_DEPTH);
  localparam int LINK_W      = IDX_W + 1;

  localparam int COUNT_W     = 11;
  localparam int BYTES_W     = 17;
  localparam int OFFSET_W    = 26;
  localparam int STATUS_W    = 2;
  localparam int PROD_W      = IDX_W + BYTES_W;

  // Upper bound on the usable pool, whatever block_count says.
  localparam logic [COUNT_W-1:0] LIMIT_CAP = COUNT_W'(LINK_DEPTH);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = BYTES_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 17'd64;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    block_index;
    logic [OFFSET_W-1:0] byte_offset;
  } fbpa_result_t;

endpackage

### rtl/fbpa_if.sv
// ----------------------------------------------------------------------------
// fbpa_if
// Valid/ready channels for allocator commands and allocator results.
// ----------------------------------------------------------------------------
interface fbpa_cmd_if
  import fbpa_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [IDX_W-1:0] free_index;

  modport source (output valid, output cmd, output free_index, input ready);
  modport sink   (input valid, input cmd, input free_index, output ready);
endinterface

interface fbpa_res_if
  import fbpa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    block_index;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (output valid, output status, output block_index, output byte_offset,
                  input ready);
  modport sink   (input valid, input status, input block_index, input byte_offset,
                  output ready);
endinterface

### rtl/fixed_block_pool_allocator_unit.sv
// Flow: an accepted command's status and index are registered in the sequencer,
//   then pushed into the result queue, whose output register drives the result beat.
// Commands: no new command is taken while one is in its result state or the
//   result queue is full; a pop reads the next link through the registered RAM port.
// Reset: synchronous, active low; the free list is empty, the bump counter is
//   zero and block_count/block_bytes return to 1024/64. The link RAM is not cleared.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-block pool allocator with a LIFO free list and a bump counter.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit
  import fbpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fbpa_cmd_if.sink              in_if,
  fbpa_res_if.source            out_if
);

  // The free list is a head register in the sequencer plus a next-link RAM.
  // Each link word holds a "next exists" bit above the next block index.
  // A free writes the old head into the link of the freed block and makes
  // that block the head. An allocate with a non-empty list reads the link of
  // the head in the accept beat and installs it as the new head in the next
  // cycle. Only one command is in flight, so a read and a write to the same
  // entry never overlap and no forwarding is needed.

  logic                 link_we;
  logic [LINK_AW-1:0]   link_waddr;
  logic [LINK_W-1:0]    link_wdata;
  logic                 link_re;
  logic [LINK_AW-1:0]   link_raddr;
  logic [LINK_W-1:0]    link_rdata;
  logic                 res_push;
  fbpa_result_t         res_data;
  logic                 q_full;

  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_if      (in_if),
    .q_full     (q_full),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_re    (link_re),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  fbpa_link_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // The two-entry queue lets a new command be accepted while an earlier
  // result beat is still waiting for the consumer.
  fbpa_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (q_full),
    .out_if    (out_if)
  );

endmodule

### rtl/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// fbpa_link_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbpa_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fbpa_res_queue.sv
// ----------------------------------------------------------------------------
// fbpa_res_queue
// Two-entry result queue: output register plus skid entry.
// ----------------------------------------------------------------------------
module fbpa_res_queue
  import fbpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fbpa_result_t      push_data,
  output logic              full,
  fbpa_res_if.source        out_if
);

  fbpa_result_t slot0_r, slot0_nxt;
  fbpa_result_t slot1_r, slot1_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         pop;

  assign pop  = out_if.valid && out_if.ready;
  assign full = (count_r == 2'd2);

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    count_nxt = count_r;
    case ({push, pop})
      2'b11: begin
        if (count_r == 2'd2) begin
          slot0_nxt = slot1_r;
          slot1_nxt = push_data;
        end else begin
          slot0_nxt = push_data;
        end
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b10: begin
        if (count_r == 2'd0) begin
          slot0_nxt = push_data;
        end else begin
          slot1_nxt = push_data;
        end
        count_nxt = count_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_if.valid       = (count_r != 2'd0);
  assign out_if.status      = slot0_r.status;
  assign out_if.block_index = slot0_r.block_index;
  assign out_if.byte_offset = slot0_r.byte_offset;

endmodule

### rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Command sequencer: free-list head, bump counter, link access and offset.
// ----------------------------------------------------------------------------
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fbpa_cmd_if.sink              in_if,
  input  logic                  q_full,
  output logic                  link_we,
  output logic [LINK_AW-1:0]    link_waddr,
  output logic [LINK_W-1:0]     link_wdata,
  output logic                  link_re,
  output logic [LINK_AW-1:0]    link_raddr,
  input  logic [LINK_W-1:0]     link_rdata,
  output logic                  res_push,
  output fbpa_result_t          res_data
);

  typedef enum logic {S_IDLE, S_RESULT} state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [COUNT_W-1:0]  bump_r, bump_nxt;
  logic [COUNT_W-1:0]  block_count_r, block_count_nxt;
  logic [BYTES_W-1:0]  block_bytes_r, block_bytes_nxt;
  logic                pop_r, pop_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [COUNT_W-1:0]  limit;
  logic                accept;
  logic [PROD_W-1:0]   prod;

  assign limit       = (block_count_r > LIMIT_CAP) ? LIMIT_CAP : block_count_r;
  assign in_if.ready = (state_r == S_IDLE) && !q_full;
  assign accept      = in_if.valid && in_if.ready;

  // The pop path reads the link of the current head in the accept cycle.
  assign link_raddr = head_r[LINK_AW-1:0];
  assign link_waddr = in_if.free_index[LINK_AW-1:0];
  assign link_wdata = {head_valid_r, head_r};

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    head_valid_nxt  = head_valid_r;
    bump_nxt        = bump_r;
    block_count_nxt = block_count_r;
    block_bytes_nxt = block_bytes_r;
    pop_nxt         = pop_r;
    status_nxt      = status_r;
    idx_nxt         = idx_r;
    link_we         = 1'b0;
    link_re         = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_COUNT: block_count_nxt = cfg_wdata[COUNT_W-1:0];
        CFG_BLOCK_BYTES: block_bytes_nxt = cfg_wdata[BYTES_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_RESULT;
          pop_nxt    = 1'b0;
          status_nxt = STATUS_OK;
          idx_nxt    = '0;
          if (in_if.cmd == CMD_ALLOC) begin
            if (head_valid_r) begin
              idx_nxt = head_r;
              pop_nxt = 1'b1;
              link_re = 1'b1;
            end else if (bump_r < limit) begin
              idx_nxt  = bump_r[IDX_W-1:0];
              bump_nxt = bump_r + COUNT_W'(1);
            end else begin
              status_nxt = STATUS_EXHAUSTED;
            end
          end else begin
            if ({1'b0, in_if.free_index} >= limit) begin
              status_nxt = STATUS_RANGE;
            end else begin
              link_we        = 1'b1;
              head_nxt       = in_if.free_index;
              head_valid_nxt = 1'b1;
            end
          end
        end
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
        if (pop_r) begin
          head_valid_nxt = link_rdata[IDX_W];
          head_nxt       = link_rdata[IDX_W-1:0];
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      head_valid_r  <= 1'b0;
      bump_r        <= '0;
      block_count_r <= BLOCK_COUNT_RST;
      block_bytes_r <= BLOCK_BYTES_RST;
      pop_r         <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      head_valid_r  <= head_valid_nxt;
      bump_r        <= bump_nxt;
      block_count_r <= block_count_nxt;
      block_bytes_r <= block_bytes_nxt;
      pop_r         <= pop_nxt;
    end
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
  end

  assign prod                 = PROD_W'(idx_r) * PROD_W'(block_bytes_r);
  assign res_push             = (state_r == S_RESULT);
  assign res_data.status      = status_r;
  assign res_data.block_index = idx_r;
  assign res_data.byte_offset = prod[OFFSET_W-1:0];

  // Every accepted command yields exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> res_push)
    else $error("accepted command produced no result");

  a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> $past(accept))
    else $error("result without an accepted command");

  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= LIMIT_CAP)
    else $error("bump counter beyond pool capacity");

  // The list can only become non-empty through a free.
  a_list_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(head_valid_r) |-> $past(accept && in_if.cmd == CMD_FREE))
    else $error("free list filled without a free");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !$past(q_full))
    else $error("command accepted with result queue full");

endmodule
